### sv/text_cell_terminal_writer_core_macros.svh
// Assertion macros for the text cell terminal writer.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TEXT_CELL_TERMINAL_WRITER_CORE_MACROS_SVH
`define TEXT_CELL_TERMINAL_WRITER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tcw check failed: same-cycle rule");

// Next-cycle implication.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tcw check failed: next-cycle rule");

`endif

### sv/tcw_pkg.sv
// Shared types and constants for the text cell terminal writer.
// No dependencies; imported by text_cell_terminal_writer_core.
package tcw_pkg;

    // Screen geometry (COLUMNS 8..128, ROWS 2..64, ROWS*COLUMNS <= 2047)
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_RETURN  = 8'h0D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] ATTR_RESET   = 8'h3F;

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Register index of colour_attr (byte address 4 * index)
    localparam logic REG_COLOUR = 1'b0;

    typedef enum logic [1:0] {
        S_INIT,
        S_RUN,
        S_CLEAR
    } t_state;

    typedef struct packed {
        logic             req_type;
        logic [7:0]       char_code;
        logic [IDX_W-1:0] read_index;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0]  cell_index;
        logic [CELL_W-1:0] cell_value;
        logic              cell_written;
        logic              screen_cleared;
    } t_result;

endpackage

### sv/text_cell_terminal_writer_core.sv
// Character-cell console writer: cursor logic, screen store and APB register.
// Depends on tcw_pkg and text_cell_terminal_writer_core_macros.svh.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-------------------------------
//  request   | start / busy            | i_req    (tcw_pkg::t_req)
//  result    | o_done (one-cycle pulse)| o_result (tcw_pkg::t_result)
//  config    | APB psel/penable/pready | pwdata[7:0] -> colour_attr
//
// One word per cycle when running: each accepted request yields its result
// in the next cycle, a read taking the store's registered read port.
// After reset the store is swept to zero, one cell at a time, busy high.
// A put that scrolls off the bottom clears the store: the character goes to
// cell 0 at once, then the remaining CELLS-1 cells are filled with blanks,
// busy high. The result side has no stall.
module text_cell_terminal_writer_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  tcw_pkg::t_req    i_req,
    output logic             o_done,
    output tcw_pkg::t_result o_result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import tcw_pkg::*;

    `include "text_cell_terminal_writer_core_macros.svh"

    localparam logic [COL_W-1:0] COLUMNS_C = COL_W'(COLUMNS);
    localparam logic [ROW_W-1:0] ROWS_C    = ROW_W'(ROWS);
    localparam logic [IDX_W-1:0] COLS_I    = IDX_W'(COLUMNS);
    localparam logic [IDX_W-1:0] CELLS_I   = IDX_W'(CELLS);
    localparam logic [IDX_W-1:0] LAST_I    = IDX_W'(CELLS - 1);

    // Screen store, one write or one read per cycle
    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] r_q;

    t_state r_state, n_state;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [IDX_W-1:0]  r_sweep, n_sweep;
    logic [CELL_W-1:0] r_fill, n_fill;
    logic [7:0]        r_attr;

    // Result registers
    logic              r_done, n_done;
    logic              r_is_read, n_is_read;
    logic              r_rd_ok, n_rd_ok;
    t_result           r_res, n_res;

    logic              w_accept;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    logic [CELL_W-1:0] w_wdata;
    logic              w_re;

    // Put datapath
    logic              w_wrap;
    logic [COL_W-1:0]  w_col_w;
    logic [ROW_W-1:0]  w_row_a;
    logic              w_clear;
    logic [IDX_W-1:0]  w_idx;
    logic [CELL_W-1:0] w_val;

    assign busy     = (r_state != S_RUN);
    assign w_accept = start && !busy;

    // Wrap the column first, then scroll check
    always_comb begin
        w_wrap  = (r_col >= COLUMNS_C);
        w_col_w = w_wrap ? (r_col - COLUMNS_C) : r_col;
        w_row_a = (w_wrap && (r_row < ROWS_C)) ? (r_row + ROW_W'(1)) : r_row;
        w_clear = (w_row_a >= ROWS_C);
        w_idx   = w_clear ? '0 : (IDX_W'(w_row_a) * COLS_I + IDX_W'(w_col_w));
        w_val   = {r_attr, i_req.char_code};
    end

    // Sequencer: next state, store access, cursor and result
    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_row     = r_row;
        n_sweep   = r_sweep;
        n_fill    = r_fill;
        n_done    = 1'b0;
        n_is_read = r_is_read;
        n_rd_ok   = r_rd_ok;
        n_res     = r_res;
        w_we      = 1'b0;
        w_waddr   = r_sweep;
        w_wdata   = r_fill;
        w_re      = 1'b0;
        case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_wdata = '0;
                n_sweep = r_sweep + IDX_W'(1);
                if (r_sweep == LAST_I) begin
                    n_state = S_RUN;
                end
            end
            S_CLEAR: begin
                w_we    = 1'b1;
                n_sweep = r_sweep + IDX_W'(1);
                if (r_sweep == LAST_I) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_accept) begin
                    n_done    = 1'b1;
                    n_is_read = (i_req.req_type == REQ_READ);
                    n_rd_ok   = 1'b0;
                    n_res     = '0;
                    if (i_req.req_type == REQ_READ) begin
                        n_res.cell_index = i_req.read_index;
                        n_rd_ok          = (i_req.read_index < CELLS_I);
                        w_re             = n_rd_ok;
                    end else if (i_req.char_code == CHAR_NEWLINE) begin
                        n_col = '0;
                        if (r_row < ROWS_C) begin
                            n_row = r_row + ROW_W'(1);
                        end
                    end else if (i_req.char_code != CHAR_RETURN) begin
                        w_we    = 1'b1;
                        w_waddr = w_idx;
                        w_wdata = w_val;
                        n_res.cell_index     = w_idx;
                        n_res.cell_value     = w_val;
                        n_res.cell_written   = 1'b1;
                        n_res.screen_cleared = w_clear;
                        n_col = (w_clear ? COL_W'(0) : w_col_w) + COL_W'(1);
                        n_row = w_clear ? '0 : w_row_a;
                        if (w_clear) begin
                            // cell 0 holds the character; blank the rest
                            n_state = S_CLEAR;
                            n_sweep = IDX_W'(1);
                            n_fill  = {r_attr, CHAR_SPACE};
                        end
                    end
                end
            end
            default: begin
                n_state = S_INIT;
                n_sweep = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_sweep <= '0;
            r_col   <= '0;
            r_row   <= ROW_W'(1);
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_col   <= n_col;
            r_row   <= n_row;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill    <= n_fill;
        r_is_read <= n_is_read;
        r_rd_ok   <= n_rd_ok;
        r_res     <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_q <= mem[i_req.read_index];
        end
    end

    always_comb begin
        o_result = r_res;
        if (r_is_read) begin
            o_result.cell_value = r_rd_ok ? r_q : '0;
        end
    end
    assign o_done = r_done;

    // APB register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_COLOUR)) begin
            r_attr <= pwdata[7:0];
        end
    end
    assign prdata = (paddr[2] == REG_COLOUR) ? {24'd0, r_attr} : 32'd0;

    `TCW_ASSERT_NEXT(a_done_follows_accept, i_clk, i_rst_n, w_accept, o_done)
    `TCW_ASSERT_NEXT(a_no_spurious_done, i_clk, i_rst_n, !w_accept, !o_done)
    `TCW_ASSERT_NOW(a_clear_at_home, i_clk, i_rst_n, o_done && o_result.screen_cleared,
        (o_result.cell_index == '0) && o_result.cell_written && busy)
    `TCW_ASSERT_NOW(a_cursor_bounds, i_clk, i_rst_n, 1'b1,
        (r_col <= COLUMNS_C) && (r_row <= ROWS_C))

endmodule

### tb/sv/text_cell_terminal_writer_core_tb.sv
// Self-checking testbench for text_cell_terminal_writer_core: directed table, then random text.
// Depends on tcw_pkg and the core; the expected words come from the directed table or a local model of the console.
`timescale 1ns / 1ps

module text_cell_terminal_writer_core_tb;
    import tcw_pkg::*;

    localparam int HALF_PERIOD = 2;           // 4 ns clock
    localparam int PHASE_WORDS = 400;         // four colour phases, about 1600 requests
    localparam int LIMIT_NS    = 50_000_000;  // several times a run
                                              // in which every put clears the store
    localparam int DRAIN_MAX   = 5000;        // covers one full clear sweep at the end

    // One row of the directed table. When pinned, want is the word to expect;
    // otherwise the console model decides.
    typedef struct {
        t_req    req;
        int      reps;
        bit      pinned;
        t_result want;
    } t_dir_row;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_req        i_req   = '0;
    logic        o_done;
    t_result     o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Travels with i_req so the monitor knows whether a typed-in word applies.
    logic        row_pinned = 1'b0;
    t_result     row_expect = '0;

    // Console model: screen copy, cursor and colour.
    logic [15:0] screen_model [CELLS];
    int unsigned cur_col;
    int unsigned cur_row;
    logic [7:0]  attr_model;

    t_result     cell_q [$];   // words still to come from the core, oldest first
    int          err_count = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    text_cell_terminal_writer_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= 100) begin
            $display("[%0t] mismatch, %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        end
    endtask

    // Applies one request to the console model and returns the word it yields.
    function automatic t_result predict_cell(input t_req r);
        t_result     res;
        int unsigned idx;
        res = '0;
        if (r.req_type == REQ_READ) begin
            res.cell_index = r.read_index;
            // reads past the last cell return zero
            if (r.read_index < CELLS) begin
                res.cell_value = screen_model[r.read_index];
            end
        end else if (r.char_code == CHAR_NEWLINE) begin
            cur_col = 0;
            if (cur_row < ROWS) cur_row++;   // row saturates at ROWS
        end else if (r.char_code != CHAR_RETURN) begin
            // wrap is deferred until the next character that is written
            if (cur_col >= COLUMNS) begin
                cur_col -= COLUMNS;
                if (cur_row < ROWS) cur_row++;
            end
            // off the bottom: blank the whole screen in the current colour
            if (cur_row >= ROWS) begin
                for (int k = 0; k < CELLS; k++) begin
                    screen_model[k] = {attr_model, CHAR_SPACE};
                end
                cur_col = 0;
                cur_row = 0;
                res.screen_cleared = 1'b1;
            end
            idx = cur_row * COLUMNS + cur_col;
            res.cell_index   = idx[IDX_W-1:0];
            res.cell_value   = {attr_model, r.char_code};
            res.cell_written = 1'b1;
            screen_model[idx] = {attr_model, r.char_code};
            cur_col++;
        end
        return res;
    endfunction

    function automatic t_dir_row dir_row(input logic rt, input logic [7:0] ch,
                                         input logic [IDX_W-1:0] ri, input int reps,
                                         input bit pinned, input logic [IDX_W-1:0] wi,
                                         input logic [15:0] wv, input logic ww,
                                         input logic wc);
        t_dir_row d;
        d.req.req_type          = rt;
        d.req.char_code         = ch;
        d.req.read_index        = ri;
        d.reps                  = reps;
        d.pinned                = pinned;
        d.want.cell_index       = wi;
        d.want.cell_value       = wv;
        d.want.cell_written     = ww;
        d.want.screen_cleared   = wc;
        return d;
    endfunction

    // Monitor: a request is taken when start is high and busy low at the edge;
    // every o_done pulse is one word and is matched against the oldest entry.
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (start && !busy) begin
                want = predict_cell(i_req);
                cell_q.push_back(row_pinned ? row_expect : want);
            end
            if (o_done) begin
                got = o_result;
                if (cell_q.size() == 0) begin
                    report_mismatch("word with nothing expected", 32'(got), 32'd0);
                end else begin
                    want = cell_q.pop_front();
                    if (got.cell_index != want.cell_index)
                        report_mismatch("cell_index", 32'(got.cell_index),
                                        32'(want.cell_index));
                    if (got.cell_value != want.cell_value)
                        report_mismatch("cell_value", 32'(got.cell_value),
                                        32'(want.cell_value));
                    if (got.cell_written != want.cell_written)
                        report_mismatch("cell_written", 32'(got.cell_written),
                                        32'(want.cell_written));
                    if (got.screen_cleared != want.screen_cleared)
                        report_mismatch("screen_cleared", 32'(got.screen_cleared),
                                        32'(want.screen_cleared));
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance,
    // start still high so a following request goes out back to back.
    task automatic send_word(input t_req r, input logic pinned, input t_result exp);
        start      <= 1'b1;
        i_req      <= r;
        row_pinned <= pinned;
        row_expect <= exp;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic maybe_idle(input bit calm);
        int n;
        if (!calm && $urandom_range(0, 99) < 15) begin
            n = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Hold the sender until every word is back and any clear sweep has ended.
    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge i_clk);
        while (cell_q.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // APB write of the colour register, then a read back of the same address.
    task automatic set_colour(input logic [7:0] v);
        wait_quiet();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_COLOUR, 2'b00};
        pwdata  <= {24'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        attr_model = v;
        // psel stays high: straight into the setup cycle of the read
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata != {24'd0, v}) report_mismatch("colour read back", prdata, {24'd0, v});
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Watchdog: any hang ends the run as a failure.
    initial begin
        #(LIMIT_NS);
        $display("text_cell_terminal_writer_core_tb: errors");
        $finish;
    end

    initial begin
        t_dir_row dir_tab [$];
        t_req     r;
        int       pick;
        int       burst;
        int       sent;
        int       drain;
        bit       calm;

        for (int k = 0; k < CELLS; k++) screen_model[k] = '0;
        cur_col    = 0;
        cur_row    = 1;
        attr_model = ATTR_RESET;

        // Directed table, colour at its reset value. The cursor starts on row 1.
        dir_tab.push_back(dir_row(REQ_READ, 8'h00, 11'd0,    1, 1, 11'd0,    16'h0000, 0, 0));
        dir_tab.push_back(dir_row(REQ_READ, 8'hFF, 11'd1999, 1, 1, 11'd1999, 16'h0000, 0, 0));
        // past the end of the store
        dir_tab.push_back(dir_row(REQ_READ, 8'h00, 11'd2000, 1, 1, 11'd2000, 16'h0000, 0, 0));
        dir_tab.push_back(dir_row(REQ_READ, 8'h00, 11'd2047, 1, 1, 11'd2047, 16'h0000, 0, 0));
        dir_tab.push_back(dir_row(REQ_PUT,  8'h41, 11'h7FF,  1, 1, 11'd80,   16'h3F41, 1, 0));
        dir_tab.push_back(dir_row(REQ_READ, 8'h00, 11'd80,   1, 1, 11'd80,   16'h3F41, 0, 0));
        // carriage return does nothing
        dir_tab.push_back(dir_row(REQ_PUT, CHAR_RETURN, 11'h7FF, 1, 1, 11'd0, 16'h0000, 0, 0));
        // high-bit bytes stay unsigned
        dir_tab.push_back(dir_row(REQ_PUT,  8'hFF, 11'd0,    1, 1, 11'd81,   16'h3FFF, 1, 0));
        dir_tab.push_back(dir_row(REQ_PUT,  8'h00, 11'h555,  1, 1, 11'd82,   16'h3F00, 1, 0));
        dir_tab.push_back(dir_row(REQ_PUT,  8'h80, 11'h2AA,  1, 1, 11'd83,   16'h3F80, 1, 0));
        dir_tab.push_back(dir_row(REQ_PUT, CHAR_NEWLINE, 11'd0, 1, 1, 11'd0, 16'h0000, 0, 0));
        dir_tab.push_back(dir_row(REQ_PUT,  8'h7F, 11'd0,    1, 0, 11'd0,    16'h0000, 0, 0));
        dir_tab.push_back(dir_row(REQ_READ, 8'h00, 11'd83,   1, 0, 11'd0,    16'h0000, 0, 0));
        // enough newlines to push the row past the bottom and saturate it
        dir_tab.push_back(dir_row(REQ_PUT, CHAR_NEWLINE, 11'd0, 25, 1, 11'd0, 16'h0000, 0, 0));
        // next character clears the screen and lands in the top left
        dir_tab.push_back(dir_row(REQ_PUT,  8'h5A, 11'd0,    1, 1, 11'd0,    16'h3F5A, 1, 1));
        dir_tab.push_back(dir_row(REQ_READ, 8'h00, 11'd0,    1, 1, 11'd0,    16'h3F5A, 0, 0));
        dir_tab.push_back(dir_row(REQ_READ, 8'h00, 11'd1,    1, 1, 11'd1,    16'h3F20, 0, 0));
        dir_tab.push_back(dir_row(REQ_READ, 8'h00, 11'd1999, 1, 1, 11'd1999, 16'h3F20, 0, 0));
        dir_tab.push_back(dir_row(REQ_PUT,  8'h20, 11'd0,    1, 0, 11'd0,    16'h0000, 0, 0));

        // Synchronous reset, released at a falling edge; the core then sweeps the store with busy high.
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[k]) begin
            repeat (dir_tab[k].reps) begin
                maybe_idle(1'b0);
                send_word(dir_tab[k].req, dir_tab[k].pinned, dir_tab[k].want);
            end
        end

        // Random text in four colour phases. Each phase change waits for all
        // words to return, which also exercises the sender holding off.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       set_colour(8'h00);
                1:       set_colour(8'hFF);
                default: set_colour(8'($urandom_range(0, 255)));
            endcase
            sent = 0;
            while (sent < PHASE_WORDS) begin
                pick         = $urandom_range(0, 99);
                burst        = 1;
                r.req_type   = REQ_PUT;
                r.char_code  = 8'($urandom_range(0, 255));
                r.read_index = 11'($urandom_range(0, 2047));
                if (pick < 10) begin
                    r.req_type = REQ_READ;
                    if ($urandom_range(0, 4) != 0) r.read_index = 11'($urandom_range(0, CELLS - 1));
                end else if (pick < 18) begin
                    r.char_code = CHAR_NEWLINE;
                    // runs of blank lines drive the cursor off the bottom
                    if ($urandom_range(0, 3) == 0) burst = $urandom_range(2, 30);
                end else if (pick < 21) begin
                    r.char_code = CHAR_RETURN;
                end else if (pick < 85) begin
                    r.char_code = 8'($urandom_range(8'h20, 8'h7E));
                end
                // long stretch with no gaps in the second phase
                calm = (ph == 1 && sent >= 50 && sent < 300);
                repeat (burst) begin
                    maybe_idle(calm);
                    send_word(r, 1'b0, '0);
                    sent++;
                end
            end
        end

        // Drain: the last put may have started a clear sweep.
        start <= 1'b0;
        drain = 0;
        while ((cell_q.size() != 0 || busy) && drain < DRAIN_MAX) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (cell_q.size() != 0) report_mismatch("words never produced", cell_q.size(), 0);

        if (err_count == 0) begin
            $display("text_cell_terminal_writer_core_tb: clean");
        end else begin
            $display("text_cell_terminal_writer_core_tb: errors");
        end
        $finish;
    end

endmodule
